### rtl/core/swsa_pkg.sv
// ----------------------------------------------------------------------------
// swsa_pkg
// Shared types and constants of the sliding-window sender control block.
// ----------------------------------------------------------------------------
package swsa_pkg;

  localparam int MaxWindowDefault = 1024;

  localparam logic [1:0] CmdAck   = 2'd0;
  localparam logic [1:0] CmdSend  = 2'd1;
  localparam logic [1:0] CmdCheck = 2'd2;

  localparam logic [1:0] ReasonNone    = 2'd0;
  localparam logic [1:0] ReasonTimeout = 2'd1;
  localparam logic [1:0] ReasonFast    = 2'd2;

  localparam logic [2:0] RegWindow     = 3'd0;
  localparam logic [2:0] RegAlpha      = 3'd1;
  localparam logic [2:0] RegBeta       = 3'd2;
  localparam logic [2:0] RegMinDev     = 3'd3;
  localparam logic [2:0] RegInitRto    = 3'd4;
  localparam logic [2:0] RegMaxTimeout = 3'd5;
  localparam logic [2:0] RegInitCredit = 3'd6;

  localparam logic [31:0] RttReset = 32'd256000;

  // One request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic        start;
    logic        clear;
    logic [8:0]  gain;
    logic [31:0] operand;
  } swsa_mac_req_t;

endpackage

### rtl/core/swsa_mac.sv
// ----------------------------------------------------------------------------
// swsa_mac
// Shared multiply-accumulate unit: acc <= (clear ? 0 : acc) + gain * operand.
// ----------------------------------------------------------------------------
module swsa_mac (
  input  logic                   clk,
  input  swsa_pkg::swsa_mac_req_t req,
  output logic [41:0]            acc
);

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= (req.clear ? 42'd0 : acc) + 42'({1'b0, req.gain} * req.operand);
    end
  end

endmodule

### rtl/core/sliding_window_sender_ack_engine_core.sv
// Order: a send, time check, spare or non-advancing ACK command goes from S_IDLE
// to S_OUT, which raises out_valid; a repeated advancing ACK passes S_RTO first,
// and a first-attempt advancing ACK runs the 32-step slot remainder, stamp read,
// sample, four multiply-accumulate passes, two blend ends, timeout sum and output.
// One transaction at a time: the next is taken only after the result handoff,
// once no configuration write or slot recompute holds input. A window write
// blocks input and configuration while the send slot is recomputed. Reset is
// synchronous; the stamp memory is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_sender_ack_engine_core
// Sender window control with a Jacobson retransmission timeout estimator.
// ----------------------------------------------------------------------------
module sliding_window_sender_ack_engine_core #(
  parameter int MAX_WINDOW = swsa_pkg::MaxWindowDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] ack_number,
  input  logic [15:0] receiver_window,
  input  logic [31:0] now_ms,
  input  logic        all_sent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  resend_reason,
  output logic [31:0] resend_sequence,
  output logic [31:0] sent_sequence,
  output logic signed [11:0] credits_released,
  output logic [31:0] base_sequence,
  output logic [31:0] timeout_value,
  output logic [31:0] expiry_time,
  output logic        gave_up,
  output logic        all_acked
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW = $clog2(MAX_WINDOW + 1) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_STAMP, S_SAMPLE, S_E1, S_E2, S_EEND, S_D1, S_D2, S_DEND, S_RTO,
    S_OUT
  } state_t;

  state_t state;

  logic [10:0] window_size;
  logic [8:0]  alpha_gain, beta_gain;
  logic [15:0] min_deviation;
  logic [7:0]  max_timeouts;

  logic [31:0] base_seq, next_seq, released_total, rtt_estimate, rtt_deviation;
  logic [31:0] current_rto, timer_deadline, timed_out_seq;
  logic [15:0] dup_ack_count;
  logic [1:0]  dup_mod3;
  logic        timed_out_valid, stopped;
  logic [7:0]  timeout_count;

  logic [31:0] send_stamps [MAX_WINDOW];
  logic [31:0] stamp_rd;

  logic [31:0] l_ack, l_now;
  logic [15:0] l_rwin;
  logic        l_all;
  logic [31:0] sample, est;

  swsa_pkg::swsa_mac_req_t mac_req;
  logic [41:0] mac_acc;

  swsa_mac u_mac (.clk(clk), .req(mac_req), .acc(mac_acc));

  // Effective window and slot index.
  logic [WW-1:0] eff_win;
  always_comb begin
    if (window_size == 11'd0) eff_win = WW'(1);
    else if (32'(window_size) > 32'(MAX_WINDOW)) eff_win = WW'(MAX_WINDOW);
    else eff_win = WW'(window_size);
  end

  // The slot index uses the window as a modulus; the window is a register, so the
  // send slot is kept by a counter that follows next_seq, the ACK slot by a remainder.
  logic [WW-1:0] next_slot;
  logic [31:0]   ack_m1;
  logic [WW-1:0] ack_slot;
  logic [31:0]   rem_work;
  logic [5:0]    div_cnt;
  logic          div_busy;

  logic [8:0]  ga, gb;
  assign ga = (alpha_gain > 9'd256) ? 9'd256 : alpha_gain;
  assign gb = (beta_gain > 9'd256) ? 9'd256 : beta_gain;

  logic [33:0] blend_sum;
  assign blend_sum = 34'((mac_acc + 42'd128) >> 8) > 34'hFFFFFFFF ?
                     34'hFFFFFFFF : 34'((mac_acc + 42'd128) >> 8);

  logic [31:0] diff;
  assign diff = (sample > est) ? sample - est : est - sample;

  logic [31:0] floor_dev;
  assign floor_dev = (rtt_deviation > 32'(min_deviation)) ? rtt_deviation
                                                          : 32'(min_deviation);
  logic [34:0] rto_sum;
  assign rto_sum = 35'(est) + {1'b0, floor_dev, 2'b00};

  logic [31:0] rto_sat;
  assign rto_sat = (rto_sum[34:32] != 3'd0) ? 32'hFFFFFFFF : rto_sum[31:0];

  logic [31:0] elapsed;
  assign elapsed = l_now - stamp_rd;

  logic [7:0] limit;
  assign limit = (max_timeouts == 8'd0) ? 8'd1 : max_timeouts;

  logic [7:0] timeout_count_next;
  assign timeout_count_next = (timed_out_valid && timed_out_seq == base_seq) ?
                              ((timeout_count < 8'd255) ? timeout_count + 8'd1
                                                        : timeout_count)
                              : 8'd1;

  // Every third duplicate ACK; dup_mod3 follows dup_ack_count modulo three.
  logic fast_due;
  assign fast_due = (dup_ack_count >= 16'd3) && (dup_mod3 == 2'd0);

  logic check_due;
  assign check_due = (base_seq != next_seq) && ((now_ms - timer_deadline) < 32'h80000000);

  logic [31:0] eff_rw;
  assign eff_rw = (32'(l_rwin) < 32'(eff_win)) ? 32'(l_rwin) : 32'(eff_win);
  logic [31:0] cred_d;
  assign cred_d = l_ack + eff_rw - released_total;

  assign cfg_ready = (state == S_IDLE) && !out_valid && !div_busy;
  assign in_ready  = (state == S_IDLE) && !out_valid && !cfg_valid && !div_busy;

  // Stamp memory.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_ready && cmd == swsa_pkg::CmdSend &&
        !stopped) begin
      send_stamps[next_slot[AW-1:0]] <= now_ms;
    end
    stamp_rd <= send_stamps[ack_slot[AW-1:0]];
  end

  always_comb begin
    mac_req = '0;
    case (state)
      S_E1: mac_req = '{start: 1'b1, clear: 1'b1, gain: 9'(9'd256 - ga),
                        operand: rtt_estimate};
      S_E2: mac_req = '{start: 1'b1, clear: 1'b0, gain: ga, operand: sample};
      S_D1: mac_req = '{start: 1'b1, clear: 1'b1, gain: 9'(9'd256 - gb),
                        operand: rtt_deviation};
      S_D2: mac_req = '{start: 1'b1, clear: 1'b0, gain: gb, operand: diff};
      default: mac_req = '0;
    endcase
  end

  // Restoring remainder by the window, one bit a cycle, for ACKs and for
  // recomputing the send slot after a window write.
  logic [32:0] rem_try;
  assign rem_try = {rem_work[31:0], ack_m1[31]} - 33'(eff_win);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      window_size <= 11'd16; alpha_gain <= 9'd32; beta_gain <= 9'd64;
      min_deviation <= 16'd2560; max_timeouts <= 8'd50;
      base_seq <= '0; next_seq <= '0; released_total <= 32'd1;
      rtt_estimate <= swsa_pkg::RttReset; rtt_deviation <= '0;
      current_rto <= 32'd256000; timer_deadline <= '0; dup_ack_count <= 16'd1;
      dup_mod3 <= 2'd1;
      timed_out_seq <= '0; timed_out_valid <= 1'b0; timeout_count <= '0;
      stopped <= 1'b0; next_slot <= '0; div_busy <= 1'b0; div_cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swsa_pkg::RegWindow:     begin window_size <= cfg_data[10:0]; next_slot <= '0;
                                   end
          swsa_pkg::RegAlpha:      alpha_gain <= cfg_data[8:0];
          swsa_pkg::RegBeta:       beta_gain <= cfg_data[8:0];
          swsa_pkg::RegMinDev:     min_deviation <= cfg_data[15:0];
          swsa_pkg::RegInitRto:    current_rto <= cfg_data;
          swsa_pkg::RegMaxTimeout: max_timeouts <= cfg_data[7:0];
          swsa_pkg::RegInitCredit: released_total <= 32'(cfg_data[10:0]);
          default: ;
        endcase
        // Window change: recompute the send slot from next_seq.
        if (cfg_index == swsa_pkg::RegWindow) begin
          div_busy <= 1'b1; div_cnt <= '0; rem_work <= '0; ack_m1 <= next_seq;
        end
      end
      if (div_busy && state == S_IDLE) begin
        // Recompute next_slot = next_seq mod window bit-serially.
        if (!rem_try[32]) rem_work <= rem_try[31:0];
        else rem_work <= {rem_work[30:0], ack_m1[31]};
        ack_m1 <= {ack_m1[30:0], 1'b0};
        div_cnt <= div_cnt + 6'd1;
        if (div_cnt == 6'd32) begin
          div_busy <= 1'b0;
          next_slot <= WW'(rem_work);
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            l_ack <= ack_number; l_rwin <= receiver_window;
            l_now <= now_ms; l_all <= all_sent;
            sent_sequence <= (cmd == swsa_pkg::CmdSend && !stopped) ? next_seq : '0;
            credits_released <= '0;
            case (cmd)
              swsa_pkg::CmdAck: begin
                if (ack_number > base_seq) begin
                  resend_reason <= swsa_pkg::ReasonNone;
                  resend_sequence <= '0;
                  if (dup_ack_count == 16'd1) begin
                    ack_m1 <= ack_number - 32'd1; rem_work <= '0; div_cnt <= '0;
                    state <= S_RD;
                  end else begin
                    state <= S_RTO;
                  end
                end else begin
                  state <= S_OUT;
                  if (ack_number == base_seq && fast_due) begin
                    resend_reason <= swsa_pkg::ReasonFast;
                    resend_sequence <= base_seq;
                    timer_deadline <= now_ms + (current_rto >> 8);
                  end else begin
                    resend_reason <= swsa_pkg::ReasonNone;
                    resend_sequence <= '0;
                  end
                  if (ack_number == base_seq) begin
                    dup_ack_count <= dup_ack_count + 16'd1;
                    // The count wraps from 65535, a multiple of three, to zero.
                    if (dup_ack_count == 16'hFFFF || dup_mod3 == 2'd2) dup_mod3 <= 2'd0;
                    else dup_mod3 <= dup_mod3 + 2'd1;
                  end
                end
              end
              swsa_pkg::CmdCheck: begin
                state <= S_OUT;
                if (!stopped && check_due) begin
                  timeout_count <= timeout_count_next;
                  timed_out_seq <= base_seq; timed_out_valid <= 1'b1;
                  if (timeout_count_next >= limit) begin
                    stopped <= 1'b1;
                    resend_reason <= swsa_pkg::ReasonNone;
                    resend_sequence <= '0;
                  end else begin
                    resend_reason <= swsa_pkg::ReasonTimeout;
                    resend_sequence <= base_seq;
                    timer_deadline <= now_ms + (current_rto >> 8);
                  end
                end else begin
                  resend_reason <= swsa_pkg::ReasonNone;
                  resend_sequence <= '0;
                end
              end
              default: begin
                state <= S_OUT;
                resend_reason <= swsa_pkg::ReasonNone;
                resend_sequence <= '0;
                if (cmd == swsa_pkg::CmdSend && !stopped) begin
                  if (next_slot == '0) timer_deadline <= now_ms + (current_rto >> 8);
                  next_seq <= next_seq + 32'd1;
                  next_slot <= (next_slot + WW'(1) == eff_win) ? '0 : next_slot + WW'(1);
                end
              end
            endcase
          end
        end
        S_RD: begin
          // Remainder loop: 32 steps, then read the stamp.
          if (!rem_try[32]) rem_work <= rem_try[31:0];
          else rem_work <= {rem_work[30:0], ack_m1[31]};
          ack_m1 <= {ack_m1[30:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd31) state <= S_STAMP;
        end
        S_STAMP: state <= S_SAMPLE;
        S_SAMPLE: begin
          sample <= (elapsed[31:24] != 8'd0) ? 32'hFFFFFFFF : {elapsed[23:0], 8'd0};
          state <= S_E1;
        end
        S_E1: state <= S_E2;
        S_E2: state <= S_EEND;
        S_EEND: begin est <= blend_sum[31:0]; state <= S_D1; end
        S_D1: state <= S_D2;
        S_D2: state <= S_DEND;
        S_DEND: begin
          rtt_deviation <= blend_sum[31:0];
          rtt_estimate <= est;
          state <= S_RTO;
        end
        S_RTO: begin
          if (dup_ack_count == 16'd1) begin
            current_rto <= rto_sat;
            timer_deadline <= l_now + (rto_sat >> 8);
          end else begin
            timer_deadline <= l_now + (current_rto >> 8);
          end
          base_seq <= l_ack;
          if (!cred_d[31] && cred_d > 32'd1024) credits_released <= 12'sd1024;
          else if (cred_d[31] && cred_d < 32'hFFFFFC00) credits_released <= -12'sd1024;
          else credits_released <= cred_d[11:0];
          released_total <= l_ack + eff_rw;
          dup_ack_count <= 16'd1;
          dup_mod3 <= 2'd1;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ack_slot = WW'(rem_work);
  assign base_sequence = base_seq;
  assign timeout_value = current_rto;
  assign expiry_time = timer_deadline;
  assign gave_up = stopped;
  assign all_acked = l_all && (base_seq == next_seq);

endmodule
